// ----- design/kvt_pkg.sv -----
// Shared types and codes for the key/value table.
`default_nettype none
package kvt_pkg;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_GET    = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key;
    logic [31:0]        write_value;
  } in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] read_value;
    logic [1:0]  status;
    logic [4:0]  entry_count;
  } out_t;

  // Broadcast control for the ring of cells.
  typedef struct packed {
    logic shift;
    logic clr_all;
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- design/kvt_cell.sv -----
// One table slot: holds valid, key and value, and rotates them to its neighbor.
`default_nettype none
module kvt_cell #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  kvt_pkg::cell_ctl_t     ctl,
  input  wire                    wr_en,
  input  wire                    del_en,
  input  wire                    nb_valid,
  input  wire [KEY_BITS-1:0]     nb_key,
  input  wire [VALUE_BITS-1:0]   nb_value,
  input  wire [KEY_BITS-1:0]     wr_key,
  input  wire [VALUE_BITS-1:0]   wr_value,
  output logic                   valid,
  output logic [KEY_BITS-1:0]    key,
  output logic [VALUE_BITS-1:0]  value
);

  logic                  valid_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl.clr_all) begin
      valid_r <= 1'b0;
    end else if (ctl.shift) begin
      valid_r <= nb_valid;
    end else if (wr_en) begin
      valid_r <= 1'b1;
    end else if (del_en) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      key_r   <= nb_key;
      value_r <= nb_value;
    end else if (wr_en) begin
      key_r   <= wr_key;
      value_r <= wr_value;
    end
  end

  assign valid = valid_r;
  assign key   = key_r;
  assign value = value_r;

endmodule
`default_nettype wire

// ----- design/key_value_table_core.sv -----
// Key/value table top level: ring of slot cells scanned past one comparator.
//
// Usage: an item (action, key, write_value) enters on in_valid/in_ready and
// gives exactly one result (hit, read_value, status, entry_count) on
// out_valid/out_ready. Actions: set, get, delete, clear.
// The ENTRIES slots form a rotating ring; each cycle of a scan moves every
// entry one cell toward the head, where a single key comparator looks at it
// and notes the matching slot and the lowest free slot. After ENTRIES shifts
// the ring is back in place and the commit step updates the chosen cell
// and loads the result register.
// One item at a time: the next item transfers only in the idle step after
// the scan and the commit of the item before it, as set by the rotation
// through the shared comparator.
// in_ready is high whenever no item is in flight, even while a result waits
// in the output register. If the receiver stalls, the next item finishes its
// scan and holds in the commit step until the output register is free.
// Reset (rst_n low, synchronous) empties the table, zeroes the entry count
// and drops any pending result.
`default_nettype none
module key_value_table_core #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  wire          clk,
  input  wire          rst_n,
  input  wire          in_valid,
  output logic         in_ready,
  input  kvt_pkg::in_t in_data,
  output logic         out_valid,
  input  wire          out_ready,
  output kvt_pkg::out_t out_data
);

  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Held item
  logic [1:0]            action_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;

  // Scan results
  logic [IDX_W-1:0]      scan_idx_r;
  logic                  match_r;
  logic [IDX_W-1:0]      match_idx_r;
  logic                  free_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic [VALUE_BITS-1:0] rd_value_r;

  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;

  logic                  out_valid_r;
  kvt_pkg::out_t         out_data_r, out_data_nxt;

  // Input field extension to storage widths
  logic [KEY_BITS+31:0]   in_key_ext;
  logic [VALUE_BITS+31:0] in_value_ext;
  assign in_key_ext   = {{KEY_BITS{1'b0}}, in_data.key};
  assign in_value_ext = {{VALUE_BITS{1'b0}}, in_data.write_value};

  // Ring
  logic                  cell_valid [ENTRIES];
  logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
  logic [VALUE_BITS-1:0] cell_value [ENTRIES];
  logic [ENTRIES-1:0]    cell_wr;
  logic [ENTRIES-1:0]    cell_del;
  kvt_pkg::cell_ctl_t    ctl;

  logic in_xfer, commit_go, scan_last, head_match;
  logic wr_go, del_go;
  logic [IDX_W-1:0] wr_idx;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign scan_last = (scan_idx_r == IDX_W'(ENTRIES - 1));
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || out_ready);
  assign head_match = cell_valid[0] && (cell_key[0] == key_r);

  assign wr_go  = commit_go && (action_r == kvt_pkg::ACT_SET) && (match_r || free_r);
  assign del_go = commit_go && (action_r == kvt_pkg::ACT_DELETE) && match_r;
  assign wr_idx = match_r ? match_idx_r : free_idx_r;

  assign ctl.shift   = (state_r == S_SCAN);
  assign ctl.clr_all = commit_go && (action_r == kvt_pkg::ACT_CLEAR);

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    localparam int NB = (i + 1) % ENTRIES;

    assign cell_wr[i]  = wr_go && (wr_idx == IDX_W'(i));
    assign cell_del[i] = del_go && (match_idx_r == IDX_W'(i));

    kvt_cell #(
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_en    (cell_wr[i]),
      .del_en   (cell_del[i]),
      .nb_valid (cell_valid[NB]),
      .nb_key   (cell_key[NB]),
      .nb_value (cell_value[NB]),
      .wr_key   (key_r),
      .wr_value (value_r),
      .valid    (cell_valid[i]),
      .key      (cell_key[i]),
      .value    (cell_value[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_xfer) state_nxt = S_SCAN;
      S_SCAN:   if (scan_last) state_nxt = S_COMMIT;
      S_COMMIT: if (commit_go) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Commit result
  logic [VALUE_BITS+31:0] rd_ext;
  logic [COUNT_W+4:0]     cnt_ext;
  assign rd_ext  = {32'd0, rd_value_r};
  assign cnt_ext = {5'd0, cnt_nxt};

  always_comb begin
    cnt_nxt      = cnt_r;
    out_data_nxt = '0;
    case (action_r)
      kvt_pkg::ACT_SET: begin
        out_data_nxt.hit = match_r;
        if (!match_r) begin
          if (free_r) begin
            cnt_nxt = cnt_r + COUNT_W'(1);
          end else begin
            out_data_nxt.status = kvt_pkg::ST_FULL;
          end
        end
      end
      kvt_pkg::ACT_GET: begin
        out_data_nxt.hit = match_r;
        if (match_r) begin
          out_data_nxt.read_value = rd_ext[31:0];
        end else begin
          out_data_nxt.status = kvt_pkg::ST_NOT_FOUND;
        end
      end
      kvt_pkg::ACT_DELETE: begin
        out_data_nxt.hit = match_r;
        if (match_r) begin
          if (cnt_r != '0) cnt_nxt = cnt_r - COUNT_W'(1);
        end else begin
          out_data_nxt.status = kvt_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        cnt_nxt = '0;
      end
    endcase
    out_data_nxt.entry_count = cnt_ext[4:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit_go) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      action_r   <= in_data.action;
      key_r      <= in_key_ext[KEY_BITS-1:0];
      value_r    <= in_value_ext[VALUE_BITS-1:0];
      scan_idx_r <= '0;
      match_r    <= 1'b0;
      free_r     <= 1'b0;
    end else if (state_r == S_SCAN) begin
      scan_idx_r <= scan_idx_r + IDX_W'(1);
      // Head cell holds original slot scan_idx_r; keep the first hit of each kind
      if (head_match && !match_r) begin
        match_r     <= 1'b1;
        match_idx_r <= scan_idx_r;
        rd_value_r  <= cell_value[0];
      end
      if (!cell_valid[0] && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= scan_idx_r;
      end
    end
    if (commit_go) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
